@@ rtl/core/rcfa_pkg.sv @@
`default_nettype none
package rcfa_pkg;

    localparam int FRAMES_DEF     = 4096;
    localparam int COUNT_BITS_DEF = 16;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 12;
    localparam int FRAME_W  = 12;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 16;
    localparam int FREE_W   = 13;
    localparam int LIMIT_W  = 13;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_SEED    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLAIM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNREF   = 2'd3;

    typedef struct packed {
        logic clr;
        logic load;
        logic eval;
        logic push;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic early_fail;
        logic need_push;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/core/rcfa_ram.sv @@
`default_nettype none
module rcfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/rcfa_ctrl.sv @@
`default_nettype none
module rcfa_ctrl
    import rcfa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_PSH  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.early_fail ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_push ? S_PSH : S_DONE;
            end
            S_PSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/rcfa_dp.sv @@
`default_nettype none
module rcfa_dp
    import rcfa_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [LIMIT_W-1:0]   i_cfg_wdata,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [INDEX_W-1:0]   i_index,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tvalid,
    output logic [FRAME_W-1:0]        o_frame,
    output logic [STATUS_W-1:0]       o_status,
    output logic [REF_W-1:0]          o_ref,
    output logic [FREE_W-1:0]         o_free
);

    localparam int FAW  = $clog2(FRAMES);
    localparam int LW   = $clog2(FRAMES + 1);
    localparam int IXW  = (FAW > INDEX_W) ? FAW : INDEX_W;
    localparam int CMPW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int RXW  = (COUNT_BITS > REF_W) ? COUNT_BITS : REF_W;
    localparam int FXW  = (LW > FREE_W) ? LW : FREE_W;
    localparam int SW   = COUNT_BITS + 1;
    localparam logic [LW-1:0]         NIL     = LW'(FRAMES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // control state
    logic [LIMIT_W-1:0]    r_limit;
    logic [LW-1:0]         r_top;
    logic [LW-1:0]         r_free;
    logic [FAW-1:0]        r_clr;
    logic                  r_m_valid;

    // item registers
    logic [MODE_W-1:0]     r_mode;
    logic [FAW-1:0]        r_f;
    logic [LW-1:0]         r_old_top;
    logic [FRAME_W-1:0]    r_res_frame;
    logic [STATUS_W-1:0]   r_res_status;
    logic [REF_W-1:0]      r_res_ref;
    logic [FRAME_W-1:0]    r_o_frame;
    logic [STATUS_W-1:0]   r_o_status;
    logic [REF_W-1:0]      r_o_ref;
    logic [FREE_W-1:0]     r_o_free;

    // memory ports
    logic                  st_we;
    logic [FAW-1:0]        st_waddr;
    logic [SW-1:0]         st_wdata;
    logic [SW-1:0]         st_q;
    logic                  nx_we;
    logic [FAW-1:0]        nx_waddr;
    logic [LW-1:0]         nx_wdata;
    logic [LW-1:0]         nx_q;
    logic                  pv_we;
    logic [FAW-1:0]        pv_waddr;
    logic [LW-1:0]         pv_wdata;
    logic [LW-1:0]         pv_q;

    // input decode
    logic [CMPW-1:0]       lim_ext;
    logic [CMPW-1:0]       lim_eff;
    logic                  idx_ok;
    logic                  top_ok;
    logic                  in_alloc;
    logic [IXW-1:0]        ix_wide;
    logic [FAW-1:0]        in_addr;
    logic [FAW-1:0]        top_f;
    logic [IXW-1:0]        top_wide;

    // evaluation
    logic                  on;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  new_on;
    logic                  unref;
    logic                  unlink;
    logic                  need_push;
    logic                  n_ok;
    logic                  p_ok;
    logic [RXW-1:0]        ref_wide;
    logic [REF_W-1:0]      ref_sat;
    logic [FXW-1:0]        free_wide;
    logic [FREE_W-1:0]     free_sat;

    always_comb begin
        lim_ext  = CMPW'(r_limit);
        lim_eff  = (lim_ext < CMPW'(FRAMES)) ? lim_ext : CMPW'(FRAMES);
        idx_ok   = CMPW'(i_index) < lim_eff;
        top_ok   = r_top != NIL;
        in_alloc = i_mode == MODE_ALLOC;
        ix_wide  = IXW'(i_index);
        in_addr  = ix_wide[FAW-1:0];
        top_f    = r_top[FAW-1:0];
        top_wide = IXW'(top_f);
    end

    always_comb begin
        on      = st_q[COUNT_BITS];
        cnt     = st_q[COUNT_BITS-1:0];
        cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_ONE;
        n_ok    = nx_q != NIL;
        p_ok    = pv_q != NIL;
        unref   = (r_mode == MODE_RELEASE) && (cnt == '0);
        unlink  = on && ((r_mode == MODE_RESERVE) || (r_mode == MODE_ALLOC)
                         || (r_mode == MODE_CLAIM));
        need_push = !on && ((r_mode == MODE_SEED)
                            || ((r_mode == MODE_RELEASE) && (cnt == CNT_ONE)));
        case (r_mode)
            MODE_SEED:    new_cnt = '0;
            MODE_RESERVE: new_cnt = CNT_ONE;
            MODE_ALLOC:   new_cnt = cnt_inc;
            MODE_CLAIM:   new_cnt = cnt_inc;
            MODE_RELEASE: new_cnt = unref ? cnt : cnt - CNT_ONE;
            default:      new_cnt = cnt;
        endcase
        new_on    = unlink ? 1'b0 : (need_push ? 1'b1 : on);
        ref_wide  = RXW'(new_cnt);
        ref_sat   = (ref_wide > RXW'(16'hFFFF)) ? 16'hFFFF : ref_wide[REF_W-1:0];
        free_wide = FXW'(r_free);
        free_sat  = (free_wide > FXW'(13'h1FFF)) ? 13'h1FFF : free_wide[FREE_W-1:0];
    end

    always_comb begin
        st_we    = i_cmd.clr || i_cmd.eval;
        st_waddr = i_cmd.clr ? r_clr : r_f;
        st_wdata = i_cmd.clr ? '0 : {new_on, new_cnt};

        nx_we    = i_cmd.eval && ((unlink && p_ok) || need_push);
        nx_waddr = need_push ? r_f : pv_q[FAW-1:0];
        nx_wdata = need_push ? r_top : nx_q;

        pv_we    = (i_cmd.eval && ((unlink && n_ok) || need_push))
                   || (i_cmd.push && (r_old_top != NIL));
        if (i_cmd.push) begin
            pv_waddr = r_old_top[FAW-1:0];
            pv_wdata = LW'(r_f);
        end else if (need_push) begin
            pv_waddr = r_f;
            pv_wdata = NIL;
        end else begin
            pv_waddr = nx_q[FAW-1:0];
            pv_wdata = pv_q;
        end
    end

    rcfa_ram #(.WIDTH(SW), .DEPTH(FRAMES)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_f),
        .o_rdata (st_q)
    );

    rcfa_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (r_f),
        .o_rdata (nx_q)
    );

    rcfa_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (r_f),
        .o_rdata (pv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_top     <= NIL;
            r_free    <= '0;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + FAW'(1);
            end
            if (i_cmd.eval) begin
                if (unlink) begin
                    if (!p_ok && (r_top == LW'(r_f))) begin
                        r_top <= nx_q;
                    end
                    if (r_free != '0) begin
                        r_free <= r_free - LW'(1);
                    end
                end else if (need_push) begin
                    r_top  <= LW'(r_f);
                    r_free <= r_free + LW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_f          <= in_alloc ? top_f : in_addr;
            r_res_frame  <= in_alloc ? (top_ok ? top_wide[FRAME_W-1:0] : '0) : i_index;
            r_res_status <= in_alloc ? ST_EMPTY : ST_INVALID;
            r_res_ref    <= '0;
        end
        if (i_cmd.eval) begin
            r_old_top    <= r_top;
            r_res_status <= unref ? ST_UNREF : ST_OK;
            r_res_ref    <= ref_sat;
        end
        if (i_cmd.finish) begin
            r_o_frame  <= r_res_frame;
            r_o_status <= r_res_status;
            r_o_ref    <= r_res_ref;
            r_o_free   <= free_sat;
        end
    end

    always_comb begin
        o_sts.clr_last   = r_clr == FAW'(FRAMES - 1);
        o_sts.early_fail = in_alloc ? !top_ok : ((i_mode > MODE_RELEASE) || !idx_ok);
        o_sts.need_push  = need_push;
        o_sts.out_free   = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_frame    = r_o_frame;
    assign o_status   = r_o_status;
    assign o_ref      = r_o_ref;
    assign o_free     = r_o_free;

endmodule
`default_nettype wire

@@ rtl/core/refcounted_frame_allocator.sv @@
// flow: an accepted item is registered, its frame's entries are read and evaluated, and a frame
// joining the free stack is then pushed; an item that fails at once (invalid frame, unused mode,
// allocate from an empty stack) goes straight to its result; each item reads one frame's entry
// from the count and link memories, then rewrites up to three frames' entries; a finished result
// waits in the output register while the next is taken, but no item is taken before the last one
// has reached it; reset: synchronous active low, then a clearing pass over the count memory
`default_nettype none
module refcounted_frame_allocator
    import rcfa_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [LIMIT_W-1:0]   i_cfg_wdata,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // frame_index[11:0], zero pad
    input  wire logic [MODE_W-1:0]    i_s_axis_tuser,  // mode[2:0]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,  // frame_out, ref_after, free_total, pad
    output logic [STATUS_W-1:0]       o_m_axis_tuser   // status[1:0]
);

    localparam int PAD_W = M_TDATA_W - FRAME_W - REF_W - FREE_W;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [FRAME_W-1:0] frame;
    logic [REF_W-1:0]   ref_after;
    logic [FREE_W-1:0]  free_total;

    rcfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    rcfa_dp #(
        .FRAMES     (FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (i_s_axis_tuser),
        .i_index     (i_s_axis_tdata[INDEX_W-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_frame     (frame),
        .o_status    (o_m_axis_tuser),
        .o_ref       (ref_after),
        .o_free      (free_total)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, free_total, ref_after, frame};

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
module testbench;
    import rcfa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;
    localparam logic [12:0]       NIL_LINK     = 13'(FRAMES_DEF);
    localparam logic [REF_W-1:0]  COUNT_MAX    = '1;
    localparam int                CYCLE_LIMIT  = 2_000_000;
    localparam int                PHASE_ITEMS  = 180;
    localparam int                N_PHASES     = 10;
    localparam int                N_ROWS       = 23;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_out;
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    ref_after;
        logic [FREE_W-1:0]   free_total;
    } t_frame_outcome;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] frame_index;
        logic               fixed;
        t_frame_outcome     want;
    } t_req_row;

    localparam t_frame_outcome BY_PREDICTOR = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;   // frame_index[11:0], zero pad
    logic [MODE_W-1:0]    i_s_axis_tuser = '0;   // mode[2:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // frame_out, ref_after, free_total, pad
    logic [STATUS_W-1:0]  o_m_axis_tuser;        // status[1:0]

    refcounted_frame_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // frame allocator mirror
    logic [REF_W-1:0]   frame_refs   [FRAMES_DEF];
    logic [12:0]        frame_next   [FRAMES_DEF];
    logic [12:0]        frame_prev   [FRAMES_DEF];
    bit                 frame_free   [FRAMES_DEF];
    logic [12:0]        stack_head;
    int                 free_tally;
    logic [LIMIT_W-1:0] limit_reg;

    t_frame_outcome outcome_q [$];
    int             mismatches = 0;
    int             cycle_count = 0;
    int             burst_left = 0;
    bit             tx_full_speed = 1'b0;
    bit             rx_full_speed = 1'b0;
    int             rx_style = 0;
    int             rx_hold = 0;

    logic [LIMIT_W-1:0] phase_limits [N_PHASES] = '{
        13'd8191, 13'd0, 13'd1, 13'd4095, 13'd16, 13'd2, 13'd300, 13'd4096, 13'd40, 13'd128
    };

    t_req_row req_rows [N_ROWS] = '{
        '{MODE_ALLOC,   12'd0,    1'b1, '{12'd0,    ST_EMPTY,   16'd0, 13'd0}},
        '{MODE_RELEASE, 12'd0,    1'b1, '{12'd0,    ST_UNREF,   16'd0, 13'd0}},
        '{MODE_SPARE_A, 12'd4095, 1'b1, '{12'd4095, ST_INVALID, 16'd0, 13'd0}},
        '{MODE_SPARE_C, 12'd0,    1'b1, '{12'd0,    ST_INVALID, 16'd0, 13'd0}},
        '{MODE_SPARE_B, 12'hAAA,  1'b1, '{12'hAAA,  ST_INVALID, 16'd0, 13'd0}},
        '{MODE_SEED,    12'd4095, 1'b1, '{12'd4095, ST_OK,      16'd0, 13'd1}},
        '{MODE_SEED,    12'd0,    1'b0, BY_PREDICTOR},
        '{MODE_SEED,    12'd0,    1'b0, BY_PREDICTOR},
        '{MODE_SEED,    12'd1,    1'b0, BY_PREDICTOR},
        '{MODE_SEED,    12'd2,    1'b0, BY_PREDICTOR},
        '{MODE_CLAIM,   12'd1,    1'b0, BY_PREDICTOR},
        '{MODE_CLAIM,   12'd4095, 1'b0, BY_PREDICTOR},
        '{MODE_RESERVE, 12'd2,    1'b0, BY_PREDICTOR},
        '{MODE_RESERVE, 12'd3,    1'b0, BY_PREDICTOR},
        '{MODE_ALLOC,   12'd0,    1'b0, BY_PREDICTOR},
        '{MODE_ALLOC,   12'hFFF,  1'b0, BY_PREDICTOR},
        '{MODE_RELEASE, 12'd3,    1'b0, BY_PREDICTOR},
        '{MODE_CLAIM,   12'd3,    1'b0, BY_PREDICTOR},
        '{MODE_CLAIM,   12'd3,    1'b0, BY_PREDICTOR},
        '{MODE_RELEASE, 12'd3,    1'b0, BY_PREDICTOR},
        '{MODE_RELEASE, 12'd1,    1'b0, BY_PREDICTOR},
        '{MODE_SEED,    12'd2,    1'b0, BY_PREDICTOR},
        '{MODE_ALLOC,   12'd5,    1'b0, BY_PREDICTOR}
    };

    function automatic void unlink_free(input int f);
        logic [12:0] p;
        logic [12:0] n;
        if (!frame_free[f]) return;
        p = frame_prev[f];
        n = frame_next[f];
        if (n != NIL_LINK) frame_prev[n] = p;
        if (p != NIL_LINK) frame_next[p] = n;
        else if (stack_head == 13'(f)) stack_head = n;
        frame_next[f] = NIL_LINK;
        frame_prev[f] = NIL_LINK;
        frame_free[f] = 1'b0;
        if (free_tally > 0) free_tally--;
    endfunction

    function automatic void push_free(input int f);
        if (frame_free[f]) return;
        frame_next[f] = stack_head;
        frame_prev[f] = NIL_LINK;
        if (stack_head != NIL_LINK) frame_prev[stack_head] = 13'(f);
        stack_head = 13'(f);
        frame_free[f] = 1'b1;
        free_tally++;
    endfunction

    function automatic t_frame_outcome frame_op_outcome(input logic [MODE_W-1:0] m,
                                                        input logic [INDEX_W-1:0] idx);
        int             usable;
        int             f;
        t_frame_outcome r;
        usable = (limit_reg < FRAMES_DEF) ? int'(limit_reg) : FRAMES_DEF;
        f = int'(idx);
        r.frame_out = idx;
        r.status = ST_OK;
        r.ref_after = '0;
        if (m == MODE_ALLOC) begin
            if (stack_head != NIL_LINK) begin
                f = int'(stack_head);
                r.frame_out = FRAME_W'(f);
                unlink_free(f);
                if (frame_refs[f] != COUNT_MAX) frame_refs[f]++;
                r.ref_after = frame_refs[f];
            end else begin
                r.frame_out = '0;
                r.status = ST_EMPTY;
            end
        end else if (m > MODE_RELEASE || f >= usable) begin
            r.status = ST_INVALID;
        end else if (m == MODE_SEED) begin
            frame_refs[f] = '0;
            push_free(f);
        end else if (m == MODE_RESERVE) begin
            unlink_free(f);
            frame_refs[f] = 16'd1;
            r.ref_after = 16'd1;
        end else if (m == MODE_CLAIM) begin
            unlink_free(f);
            if (frame_refs[f] != COUNT_MAX) frame_refs[f]++;
            r.ref_after = frame_refs[f];
        end else begin
            if (frame_refs[f] == '0) begin
                r.status = ST_UNREF;
            end else begin
                frame_refs[f]--;
                if (frame_refs[f] == '0) push_free(f);
            end
            r.ref_after = frame_refs[f];
        end
        r.free_total = FREE_W'(free_tally);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("tb: mismatch on %s: got %0d, want %0d (cycle %0d)",
                     what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic send_req(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] idx,
                            input logic fixed, input t_frame_outcome want);
        int             gap;
        t_frame_outcome predicted;
        if (burst_left == 0 && !tx_full_speed) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1, 2: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(4, 20);
            endcase
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= m;
        i_s_axis_tdata <= {{(S_TDATA_W - INDEX_W){1'b0}}, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = frame_op_outcome(m, idx);
        outcome_q.push_back(fixed ? want : predicted);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    task automatic run_phase(input int n_items);
        int                 usable;
        int                 pool;
        int                 base;
        int                 r;
        logic [MODE_W-1:0]  m;
        logic [INDEX_W-1:0] idx;
        usable = (limit_reg < FRAMES_DEF) ? int'(limit_reg) : FRAMES_DEF;
        pool = (usable < 48) ? usable : 48;
        base = (usable > pool) ? $urandom_range(0, usable - pool) : 0;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 18) m = MODE_SEED;
            else if (r < 26) m = MODE_RESERVE;
            else if (r < 52) m = MODE_ALLOC;
            else if (r < 68) m = MODE_CLAIM;
            else if (r < 94) m = MODE_RELEASE;
            else m = MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
            r = $urandom_range(0, 99);
            if (usable == 0 || r < 10) idx = INDEX_W'($urandom_range(0, FRAMES_DEF - 1));
            else if (r < 13) idx = INDEX_W'(usable - 1);
            else if (r < 16) idx = INDEX_W'(usable);
            else idx = INDEX_W'(base + $urandom_range(0, pool - 1));
            send_req(m, idx, 1'b0, BY_PREDICTOR);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_style <= $urandom_range(0, 2);
            rx_hold <= $urandom_range(20, 200);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        if (rx_full_speed || rx_style == 0) i_m_axis_tready <= 1'b1;
        else if (rx_style == 1) i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        else i_m_axis_tready <= ($urandom_range(0, 9) == 0);
    end

    always @(posedge i_clk) begin : check_results
        t_frame_outcome want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("item with none expected", int'(o_m_axis_tdata[11:0]), 0);
            end else begin
                want = outcome_q.pop_front();
                if (o_m_axis_tdata[11:0] !== want.frame_out)
                    report_mismatch("frame_out", int'(o_m_axis_tdata[11:0]),
                                    int'(want.frame_out));
                if (o_m_axis_tuser !== want.status)
                    report_mismatch("status", int'(o_m_axis_tuser), int'(want.status));
                if (o_m_axis_tdata[27:12] !== want.ref_after)
                    report_mismatch("ref_after", int'(o_m_axis_tdata[27:12]),
                                    int'(want.ref_after));
                if (o_m_axis_tdata[40:28] !== want.free_total)
                    report_mismatch("free_total", int'(o_m_axis_tdata[40:28]),
                                    int'(want.free_total));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int f = 0; f < FRAMES_DEF; f++) begin
            frame_refs[f] = '0;
            frame_next[f] = NIL_LINK;
            frame_prev[f] = NIL_LINK;
            frame_free[f] = 1'b0;
        end
        stack_head = NIL_LINK;
        free_tally = 0;
        limit_reg = LIMIT_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++)
            send_req(req_rows[k].mode, req_rows[k].frame_index, req_rows[k].fixed,
                     req_rows[k].want);

        // back to back items, one count up and back down past zero
        tx_full_speed = 1'b1;
        rx_full_speed = 1'b1;
        for (int k = 0; k < 20; k++)
            send_req(MODE_CLAIM, 12'd100, 1'b0, BY_PREDICTOR);
        for (int k = 0; k < 21; k++)
            send_req(MODE_RELEASE, 12'd100, 1'b0, BY_PREDICTOR);
        tx_full_speed = 1'b0;
        rx_full_speed = 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(phase_limits[p]);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/rcfa_pkg.sv
rtl/core/rcfa_ram.sv
rtl/core/rcfa_ctrl.sv
rtl/core/rcfa_dp.sv
rtl/core/refcounted_frame_allocator.sv
verif/testbench.sv
